// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define MEP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mep assertion failed");

// Clocked assertion that also holds during reset.
`define MEP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mep assertion failed");

`endif

// File: design/mep_pkg.sv
// Package: constants, item type and helper functions of the escape-time pixel block.
package mep_pkg;

    // Frame and number format
    localparam int FRAME_WIDTH    = 320;
    localparam int FRAME_HEIGHT   = 240;
    localparam int MAX_ROUNDS_DEF = 32;
    localparam int FRAC_BITS      = 10;

    // Field widths
    localparam int PX_W    = 9;
    localparam int PY_W    = 8;
    localparam int COLOR_W = 24;
    localparam int COUNT_W = 6;
    localparam int IDX_W   = 17;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // Step size: (zoom*2) / FRAME_WIDTH by reciprocal multiply and one correction.
    // The vertical step works out equal to the horizontal one.
    localparam int SPAN2_W   = CFG_W + 1;
    localparam int STEP_W    = SPAN2_W;
    localparam int DIV_SHIFT = 32;
    localparam logic [31:0] DIV_RECIP = 32'((64'd1 << DIV_SHIFT) / 64'(FRAME_WIDTH));
    localparam int DIV_P_W   = SPAN2_W + 32;
    localparam logic [31:0] FW_32      = 32'(FRAME_WIDTH);
    localparam logic [31:0] FW_HALF_32 = 32'(FRAME_WIDTH / 2);
    localparam logic [31:0] FH_HALF_32 = 32'(FRAME_HEIGHT / 2);

    // Escape limit 4.0 in fixed point
    localparam logic [31:0] ESC_LIMIT = 32'(4) << FRAC_BITS;

    // Colour map
    localparam int COLOR_T_W = 5;
    localparam logic [15:0] MUL_R = 16'd8;
    localparam logic [15:0] MUL_G = 16'd5;
    localparam logic [15:0] MUL_B = 16'd13;

    // Register reset values
    localparam logic [CFG_W-1:0] CENTER_REAL_RST = 16'hFD00;
    localparam logic [CFG_W-1:0] CENTER_IMAG_RST = 16'h0000;
    localparam logic [CFG_W-1:0] ZOOM_SPAN_RST   = 16'd1536;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_REAL = 2'd0,
        REG_CENTER_IMAG = 2'd1,
        REG_ZOOM_SPAN   = 2'd2
    } t_reg_idx;

    // One pixel on its way through the rounds
    typedef struct packed {
        logic [31:0]        cr;
        logic [31:0]        ci;
        logic [31:0]        zr;
        logic [31:0]        zi;
        logic [COUNT_W-1:0] count;
        logic               done;
        logic [IDX_W-1:0]   index;
    } t_item;

    // Arithmetic right shift by the fraction width
    function automatic logic [31:0] asr_frac(input logic [31:0] v);
        return 32'($signed(v) >>> FRAC_BITS);
    endfunction

    // Count modulo 32 mapped to packed RGB
    function automatic logic [COLOR_W-1:0] color_of(input logic [COUNT_W-1:0] cnt);
        logic [15:0] t;
        t = 16'(cnt[COLOR_T_W-1:0]);
        return {8'(t * MUL_R), 8'(t * MUL_G), 8'(t * MUL_B)};
    endfunction

endpackage

// File: design/mandelbrot_escape_pixel_top.sv
// Top level of the escape-time pixel block: setup stages, round pipeline, output register.
//
// Input stream: one transfer per pixel, tdata carries the column and row.
// Output stream: one transfer per pixel with packed colour, round count and
// frame index, in input order.
// Configuration: write enable, index and data; the user must write the view centre
// and zoom only while no pixel is in flight (the block does not enforce this); they take effect for the next pixel.
// Throughput: one pixel per cycle while the output is not stalled; every round has its own pair of stages
// (three 32-bit products, then the escape test and z update).
// Path from input transfer to output valid: five setup stages (step division,
// point mapping), the rounds, and the output register.
// Stall: the whole pipeline holds while the output is valid and not taken;
// the input then shows not ready, and nothing is dropped or repeated.
// Reset: synchronous; clears every valid bit and loads the default view.
module mandelbrot_escape_pixel_top
    import mep_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input pixel: [8:0] pixel_x, [16:9] pixel_y, rest zero
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // result: [23:0] pixel_color, [29:24] escape_count, [46:30] pixel_index, [47] zero
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    logic [CFG_W-1:0] r_center_real;
    logic [CFG_W-1:0] r_center_imag;
    logic [CFG_W-1:0] r_zoom_span;

    logic w_adv;

    logic [SPAN2_W-1:0] w_span2;
    logic [31:0]        w_cr_ext;
    logic [31:0]        w_ci_ext;

    // stage 1
    logic               r_vld_s1;
    logic [PX_W-1:0]    r_px_s1;
    logic [PY_W-1:0]    r_py_s1;
    logic [DIV_P_W-1:0] r_div_p;
    // stage 2
    logic               r_vld_s2;
    logic [PX_W-1:0]    r_px_s2;
    logic [PY_W-1:0]    r_py_s2;
    logic [STEP_W-1:0]  r_q0;
    logic [31:0]        r_qw;
    logic [STEP_W-1:0]  n_q0;
    // stage 3
    logic               r_vld_s3;
    logic [PX_W-1:0]    r_px_s3;
    logic [PY_W-1:0]    r_py_s3;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic [31:0]        w_rem;
    // stage 4
    logic               r_vld_s4;
    logic [31:0]        r_pxs;
    logic [31:0]        r_pys;
    logic [31:0]        r_corn_x;
    logic [31:0]        r_corn_y;
    logic [IDX_W-1:0]   r_index_s4;
    // stage 5
    logic               r_vld_s5;
    t_item              r_item_s5;

    logic               w_vld [MAX_ROUNDS+1];
    t_item              w_item [MAX_ROUNDS+1];

    logic               r_out_vld;
    logic [M_DATA_W-1:0] r_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_real <= CENTER_REAL_RST;
            r_center_imag <= CENTER_IMAG_RST;
            r_zoom_span   <= ZOOM_SPAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CENTER_REAL: r_center_real <= i_cfg_wdata;
                REG_CENTER_IMAG: r_center_imag <= i_cfg_wdata;
                REG_ZOOM_SPAN:   r_zoom_span   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline moves unless a finished result waits
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    assign w_span2  = {r_zoom_span, 1'b0};
    assign w_cr_ext = {{16{r_center_real[CFG_W-1]}}, r_center_real};
    assign w_ci_ext = {{16{r_center_imag[CFG_W-1]}}, r_center_imag};

    // Valid bits of the setup stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
            r_vld_s3 <= 1'b0;
            r_vld_s4 <= 1'b0;
            r_vld_s5 <= 1'b0;
        end else if (w_adv) begin
            r_vld_s1 <= i_s_axis_tvalid;
            r_vld_s2 <= r_vld_s1;
            r_vld_s3 <= r_vld_s2;
            r_vld_s4 <= r_vld_s3;
            r_vld_s5 <= r_vld_s4;
        end
    end

    // Step division: estimate, then one correction, then clamp to at least one
    assign n_q0  = r_div_p[DIV_P_W-1:DIV_SHIFT];
    assign w_rem = 32'(w_span2) - r_qw;

    always_comb begin
        n_step = (w_rem >= FW_32) ? r_q0 + STEP_W'(1) : r_q0;
        if (n_step == '0) begin
            n_step = STEP_W'(1);
        end
    end

    // Setup stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 1: reciprocal product
            r_px_s1 <= i_s_axis_tdata[PX_W-1:0];
            r_py_s1 <= i_s_axis_tdata[PX_W+PY_W-1:PX_W];
            r_div_p <= DIV_P_W'(w_span2) * DIV_P_W'(DIV_RECIP);
            // stage 2: quotient estimate and its back-product
            r_px_s2 <= r_px_s1;
            r_py_s2 <= r_py_s1;
            r_q0    <= n_q0;
            r_qw    <= 32'(n_q0) * FW_32;
            // stage 3: corrected step
            r_px_s3 <= r_px_s2;
            r_py_s3 <= r_py_s2;
            r_step  <= n_step;
            // stage 4: offsets, corner and frame index
            r_pxs      <= 32'(r_px_s3) * 32'(r_step);
            r_pys      <= 32'(r_py_s3) * 32'(r_step);
            r_corn_x   <= 32'(r_step) * FW_HALF_32;
            r_corn_y   <= 32'(r_step) * FH_HALF_32;
            r_index_s4 <= IDX_W'(32'(r_py_s3) * FW_32 + 32'(r_px_s3));
            // stage 5: point c, z starts at zero
            r_item_s5.cr    <= w_cr_ext - r_corn_x + r_pxs;
            r_item_s5.ci    <= w_ci_ext - r_corn_y + r_pys;
            r_item_s5.zr    <= '0;
            r_item_s5.zi    <= '0;
            r_item_s5.count <= '0;
            r_item_s5.done  <= 1'b0;
            r_item_s5.index <= r_index_s4;
        end
    end

    // Round pipeline
    assign w_vld[0]  = r_vld_s5;
    assign w_item[0] = r_item_s5;

    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
        mep_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Output register with colour map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_vld[MAX_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {1'b0, w_item[MAX_ROUNDS].index, w_item[MAX_ROUNDS].count,
                           color_of(w_item[MAX_ROUNDS].count)};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: design/mep_round.sv
// One escape-time round: a product stage and an update stage.
module mep_round
    import mep_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic        r_vld_a;
    t_item       r_item_a;
    logic [31:0] r_sq_r;
    logic [31:0] r_sq_i;
    logic [31:0] r_cross;

    logic        r_vld_b;
    t_item       r_item_b;
    t_item       n_item_b;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_sum;
    logic        w_esc;

    // Stage a: the three products, low 32 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item_a <= i_item;
            r_sq_r   <= i_item.zr * i_item.zr;
            r_sq_i   <= i_item.zi * i_item.zi;
            r_cross  <= i_item.zr * i_item.zi;
        end
    end

    // Stage b: escape test and update of z
    assign w_a   = asr_frac(r_sq_r);
    assign w_b   = asr_frac(r_sq_i);
    assign w_sum = w_a + w_b;
    assign w_esc = $signed(w_sum) > $signed(ESC_LIMIT);

    always_comb begin
        n_item_b = r_item_a;
        if (!r_item_a.done) begin
            if (w_esc) begin
                n_item_b.done = 1'b1;
            end else begin
                n_item_b.zr    = w_a - w_b + r_item_a.cr;
                n_item_b.zi    = asr_frac({r_cross[30:0], 1'b0}) + r_item_a.ci;
                n_item_b.count = r_item_a.count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item_b <= n_item_b;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_item = r_item_b;

endmodule

// File: design/mep_checker.sv
// Port checker of the escape-time pixel block and its bind to the top level.
`include "assert_macros.svh"

module mep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // A stalled result holds its data
    `MEP_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // A blocked output also blocks the input side
    `MEP_ASSERT(a_stall_backpressure, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)

    // Red channel is the count modulo 32 times eight
    `MEP_ASSERT(a_red_matches_count, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata[23:19] == o_m_axis_tdata[28:24] && o_m_axis_tdata[18:16] == 3'b000)

    // Padding bit stays clear
    `MEP_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid |-> !o_m_axis_tdata[47])

    // Reset empties the output stage
    `MEP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (.*);
